FILE: rtl/core/keyed_request_rate_limiter_defines.svh
// Assertion macros shared by the rate limiter checker.
`ifndef KEYED_REQUEST_RATE_LIMITER_DEFINES_SVH
`define KEYED_REQUEST_RATE_LIMITER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define KRL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define KRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/krl_pkg.sv
// Shared types and constants of the keyed request rate limiter.
package krl_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(ENTRIES);

  localparam int KEY_W   = 64;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 8;
  localparam int AGE_W   = 8;
  localparam int GAP_W   = 16;
  localparam int VERD_W  = 3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AGE_LIMIT   = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT_RST = 8'd10;
  localparam logic [GAP_W-1:0]   MIN_GAP_RST     = 16'd60;
  localparam logic [AGE_W-1:0]   AGE_LIMIT_RST   = 8'd60;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 8'hFF;

  typedef enum logic [VERD_W-1:0] {
    VERD_NEW   = 3'd0,
    VERD_KNOWN = 3'd1,
    VERD_LIMIT = 3'd2,
    VERD_SOON  = 3'd3,
    VERD_FULL  = 3'd4
  } verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
    logic [AGE_W-1:0]   age;
    logic [TIME_W-1:0]  last_time;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             load;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             decide;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic out_busy;
  } dp_sts_t;

endpackage

FILE: rtl/core/krl_if.sv
// Valid/ready channel interfaces for request items and verdicts.
interface krl_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [krl_pkg::KEY_W-1:0]     request_key;
  logic [krl_pkg::TIME_W-1:0]    now_seconds;

  modport source (output valid, req_type, request_key, now_seconds, input ready);
  modport sink   (input valid, req_type, request_key, now_seconds, output ready);
endinterface

interface krl_out_if;
  logic                          valid;
  logic                          ready;
  logic [krl_pkg::VERD_W-1:0]    verdict;
  logic [krl_pkg::COUNT_W-1:0]   count_after;

  modport source (output valid, verdict, count_after, input ready);
  modport sink   (input valid, verdict, count_after, output ready);
endinterface

FILE: rtl/core/krl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module krl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/krl_ctrl.sv
// Sequencer: accepts items, walks the table, triggers the verdict.
module krl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output krl_pkg::ctrl_cmd_t  cmd,
  input  krl_pkg::dp_sts_t    sts
);

  krl_pkg::state_t            state_r, state_nxt;
  logic [krl_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       scan_done;

  assign scan_done = (cnt_r == krl_pkg::SCAN_END);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= krl_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      krl_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) state_nxt = krl_pkg::ST_SCAN;
      end
      krl_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = sts.is_tick ? krl_pkg::ST_IDLE : krl_pkg::ST_CALC;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      krl_pkg::ST_CALC: begin
        if (!sts.out_busy) state_nxt = krl_pkg::ST_DECIDE;
      end
      krl_pkg::ST_DECIDE: begin
        state_nxt = krl_pkg::ST_IDLE;
      end
      default: state_nxt = krl_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.rd_en   = 1'b0;
    cmd.rd_addr = cnt_r[krl_pkg::IDX_W-1:0];
    cmd.decide  = 1'b0;
    unique case (state_r)
      krl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      krl_pkg::ST_SCAN:   cmd.rd_en  = !scan_done;
      krl_pkg::ST_CALC:   ;
      krl_pkg::ST_DECIDE: cmd.decide = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/krl_dp.sv
// Datapath: config, item latch, entry table, scan, aging and verdict.
module krl_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [krl_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [krl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          in_req_type,
  input  logic [krl_pkg::KEY_W-1:0]     in_request_key,
  input  logic [krl_pkg::TIME_W-1:0]    in_now_seconds,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [krl_pkg::VERD_W-1:0]    out_verdict,
  output logic [krl_pkg::COUNT_W-1:0]   out_count_after,
  input  krl_pkg::ctrl_cmd_t            cmd,
  output krl_pkg::dp_sts_t              sts
);

  // configuration
  logic [krl_pkg::COUNT_W-1:0] count_limit_r;
  logic [krl_pkg::GAP_W-1:0]   min_gap_r;
  logic [krl_pkg::AGE_W-1:0]   age_limit_r;

  // latched item
  logic                        tick_r;
  logic [krl_pkg::KEY_W-1:0]   key_r;
  logic [krl_pkg::TIME_W-1:0]  now_r;

  // table
  logic [krl_pkg::ENTRIES-1:0] valid_r;
  logic                        wr_en;
  logic [krl_pkg::IDX_W-1:0]   wr_addr;
  krl_pkg::entry_t             wr_word;
  krl_pkg::entry_t             rd_word;
  logic                        rd_pend_r;
  logic [krl_pkg::IDX_W-1:0]   rd_idx_r;
  logic                        rd_live;

  // scan results
  logic                        hit_f_r, free_f_r;
  logic [krl_pkg::IDX_W-1:0]   hit_idx_r, free_idx_r;
  krl_pkg::entry_t             hit_word_r;
  logic [krl_pkg::TIME_W-1:0]  gap_r;

  // verdict
  logic                        age_keep;
  logic                        dec_wr;
  logic [krl_pkg::IDX_W-1:0]   dec_addr;
  krl_pkg::entry_t             dec_word;
  krl_pkg::verdict_t           dec_verd;
  logic [krl_pkg::COUNT_W-1:0] dec_count;
  logic                        out_valid_r;
  krl_pkg::verdict_t           verd_r;
  logic [krl_pkg::COUNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_limit_r <= krl_pkg::COUNT_LIMIT_RST;
      min_gap_r     <= krl_pkg::MIN_GAP_RST;
      age_limit_r   <= krl_pkg::AGE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        krl_pkg::REG_COUNT_LIMIT: count_limit_r <= cfg_wdata[krl_pkg::COUNT_W-1:0];
        krl_pkg::REG_MIN_GAP:     min_gap_r     <= cfg_wdata;
        krl_pkg::REG_AGE_LIMIT:   age_limit_r   <= cfg_wdata[krl_pkg::AGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tick_r <= in_req_type;
      key_r  <= in_request_key;
      now_r  <= in_now_seconds;
    end
  end

  krl_ram #(
    .WIDTH (krl_pkg::ENTRY_W),
    .DEPTH (krl_pkg::ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_word),
    .rd_en   (cmd.rd_en),
    .rd_addr (cmd.rd_addr),
    .rd_data (rd_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.rd_en;
    end
    rd_idx_r <= cmd.rd_addr;
  end

  // read data of a valid slot is back this cycle
  assign rd_live  = rd_pend_r && valid_r[rd_idx_r];
  assign age_keep = (rd_word.age < age_limit_r);

  // scan of a request: first matching valid slot, first free slot
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      hit_f_r  <= 1'b0;
      free_f_r <= 1'b0;
    end else if (rd_pend_r && !tick_r) begin
      if (rd_live && !hit_f_r && (rd_word.key == key_r)) begin
        hit_f_r    <= 1'b1;
        hit_idx_r  <= rd_idx_r;
        hit_word_r <= rd_word;
      end
      if (!valid_r[rd_idx_r] && !free_f_r) begin
        free_f_r   <= 1'b1;
        free_idx_r <= rd_idx_r;
      end
    end
  end

  // absolute time gap, settles during the calc cycle
  always_ff @(posedge clk) begin
    gap_r <= (now_r >= hit_word_r.last_time) ? (now_r - hit_word_r.last_time)
                                             : (hit_word_r.last_time - now_r);
  end

  always_comb begin
    dec_wr    = 1'b0;
    dec_addr  = hit_idx_r;
    dec_word  = hit_word_r;
    dec_verd  = krl_pkg::VERD_FULL;
    dec_count = '0;
    if (hit_f_r) begin
      dec_wr = 1'b1;
      if (hit_word_r.count >= count_limit_r) begin
        if (hit_word_r.count != krl_pkg::COUNT_MAX) begin
          dec_word.count = hit_word_r.count + 1'b1;
        end
        dec_verd  = krl_pkg::VERD_LIMIT;
        dec_count = dec_word.count;
      end else if (gap_r < {{(krl_pkg::TIME_W-krl_pkg::GAP_W){1'b0}}, min_gap_r}) begin
        dec_verd  = krl_pkg::VERD_SOON;
        dec_count = hit_word_r.count;
      end else begin
        dec_word.count     = hit_word_r.count + 1'b1;
        dec_word.last_time = now_r;
        dec_verd           = krl_pkg::VERD_KNOWN;
        dec_count          = dec_word.count;
      end
    end else if (free_f_r) begin
      dec_wr             = 1'b1;
      dec_addr           = free_idx_r;
      dec_word.key       = key_r;
      dec_word.count     = krl_pkg::COUNT_W'(1);
      dec_word.age       = krl_pkg::AGE_W'(1);
      dec_word.last_time = now_r;
      dec_verd           = krl_pkg::VERD_NEW;
      dec_count          = krl_pkg::COUNT_W'(1);
    end
  end

  // write port: aging sweep or verdict update, never both
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx_r;
    wr_word = rd_word;
    if (cmd.decide) begin
      wr_en   = dec_wr;
      wr_addr = dec_addr;
      wr_word = dec_word;
    end else if (rd_live && tick_r && age_keep) begin
      wr_en       = 1'b1;
      wr_word.age = rd_word.age + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.decide && !hit_f_r && free_f_r) begin
      valid_r[free_idx_r] <= 1'b1;
    end else if (rd_live && tick_r && !age_keep) begin
      valid_r[rd_idx_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.decide) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.decide) begin
      verd_r  <= dec_verd;
      count_r <= dec_count;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_verdict     = verd_r;
  assign out_count_after = count_r;
  assign sts.is_tick     = tick_r;
  assign sts.out_busy    = out_valid_r;

endmodule

FILE: rtl/core/keyed_request_rate_limiter.sv
// A request gives its verdict after its SCAN walk, then CALC and DECIDE;
// a tick returns to IDLE after the walk. A new item is taken only in IDLE, so both item
//   kinds are paced by the walk over the entry RAM, one read per cycle through its single read port.
// A verdict held in the output register does not block the next input transfer.
// Reset (rst_n low, synchronous): all entries invalid, registers to 10 / 60 / 60,
//   output empty; entry RAM contents are not cleared, so no clearing pass is needed.
module keyed_request_rate_limiter (
  input  logic                           clk,
  input  logic                           rst_n,
  krl_in_if.sink                         in_ch,
  krl_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [krl_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [krl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // Command and status between the sequencer and the datapath.
  krl_pkg::ctrl_cmd_t cmd;
  krl_pkg::dp_sts_t   sts;

  // Sequencer: in IDLE it takes one item, then walks every slot address once.
  // A request then forms the time gap in CALC (waiting there while the
  // previous verdict is still untaken) and writes back in DECIDE.
  // A tick returns to IDLE straight after the walk.
  krl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Datapath: valid bits in flops, key/count/age/time in one RAM word per slot.
  // During the walk each returned word is compared against the request key (first hit,
  // first free slot), or on a tick aged and written back, or invalidated at the age limit.
  krl_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .in_req_type     (in_ch.req_type),
    .in_request_key  (in_ch.request_key),
    .in_now_seconds  (in_ch.now_seconds),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_verdict     (out_ch.verdict),
    .out_count_after (out_ch.count_after),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

FILE: rtl/core/krl_chk.sv
// Port-level checker for the rate limiter, bound to the top level.
`include "keyed_request_rate_limiter_defines.svh"

module krl_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_req_type,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [krl_pkg::VERD_W-1:0]    out_verdict
);

  logic in_xfer, out_xfer;
  logic out_stall, tick_xfer;

  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;
  assign out_stall = out_valid && !out_ready;
  assign tick_xfer = in_xfer && in_req_type;

  // a pending verdict stays until taken
  `KRL_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_verdict), "verdict lost")
  // one item in work at a time
  `KRL_ASSERT_NEXT(a_busy_after_in, in_xfer, !in_ready, "second input transfer")
  // a tick never yields a result
  `KRL_ASSERT_NEXT(a_tick_silent, tick_xfer && !out_valid, !out_valid, "result after tick")
  // a verdict transfer is never directly followed by another verdict
  `KRL_ASSERT_NEXT(a_no_b2b_out, out_xfer, !out_valid, "back to back verdicts")

endmodule

bind keyed_request_rate_limiter krl_chk u_krl_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_req_type (in_ch.req_type),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_verdict (out_ch.verdict)
);

FILE: tb/krl_verdict_checker.sv
// Checker for the rate limiter: mirrors the key table from observed transfers, scores verdicts.
module krl_verdict_checker
  import krl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  krl_in_if                     in_ch,
  krl_out_if                    out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    verdict_t           verdict;
    logic [COUNT_W-1:0] count_after;
  } verdict_rec_t;

  verdict_rec_t verdicts_due[$];

  // Shadow registers.
  logic [COUNT_W-1:0] lim_count;
  logic [GAP_W-1:0]   lim_gap;
  logic [AGE_W-1:0]   lim_age;

  // Shadow key table.
  logic               slot_used  [ENTRIES];
  logic [KEY_W-1:0]   slot_key   [ENTRIES];
  logic [COUNT_W-1:0] slot_hits  [ENTRIES];
  logic [AGE_W-1:0]   slot_age   [ENTRIES];
  logic [TIME_W-1:0]  slot_stamp [ENTRIES];

  function automatic void age_table();
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i]) begin
        if (slot_age[i] >= lim_age) slot_used[i] = 1'b0;
        else slot_age[i] = slot_age[i] + 1'b1;
      end
    end
  endfunction

  function automatic verdict_rec_t judge_request(input logic [KEY_W-1:0]  key,
                                                 input logic [TIME_W-1:0] now);
    int                hit;
    int                spare;
    logic [TIME_W-1:0] gap;
    verdict_rec_t      rec;
    hit   = -1;
    spare = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i]) begin
        if (hit < 0 && slot_key[i] == key) hit = i;
      end else if (spare < 0) begin
        spare = i;
      end
    end
    if (hit < 0) begin
      if (spare < 0) begin
        rec.verdict     = VERD_FULL;
        rec.count_after = '0;
      end else begin
        slot_used[spare]  = 1'b1;
        slot_key[spare]   = key;
        slot_hits[spare]  = COUNT_W'(1);
        slot_age[spare]   = AGE_W'(1);
        slot_stamp[spare] = now;
        rec.verdict       = VERD_NEW;
        rec.count_after   = COUNT_W'(1);
      end
      return rec;
    end
    if (slot_hits[hit] >= lim_count) begin
      if (slot_hits[hit] != COUNT_MAX) slot_hits[hit] = slot_hits[hit] + 1'b1;
      rec.verdict     = VERD_LIMIT;
      rec.count_after = slot_hits[hit];
      return rec;
    end
    gap = (now >= slot_stamp[hit]) ? now - slot_stamp[hit] : slot_stamp[hit] - now;
    if (gap < TIME_W'(lim_gap)) begin
      rec.verdict     = VERD_SOON;
      rec.count_after = slot_hits[hit];
      return rec;
    end
    slot_stamp[hit] = now;
    slot_hits[hit]  = slot_hits[hit] + 1'b1;
    rec.verdict     = VERD_KNOWN;
    rec.count_after = slot_hits[hit];
    return rec;
  endfunction

  always @(posedge clk) begin : watch
    verdict_rec_t want;
    if (!rst_n) begin
      lim_count  = COUNT_LIMIT_RST;
      lim_gap    = MIN_GAP_RST;
      lim_age    = AGE_LIMIT_RST;
      fail_count = 0;
      for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
      verdicts_due.delete();
    end else begin
      if (cfg_we === 1'b1) begin
        case (cfg_idx)
          REG_COUNT_LIMIT: lim_count = cfg_wdata[COUNT_W-1:0];
          REG_MIN_GAP:     lim_gap   = cfg_wdata[GAP_W-1:0];
          REG_AGE_LIMIT:   lim_age   = cfg_wdata[AGE_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (verdicts_due.size() == 0) begin
          $error("verdict transfer with nothing expected: verdict %0d count_after %0d",
                 out_ch.verdict, out_ch.count_after);
          fail_count++;
        end else begin
          want = verdicts_due.pop_front();
          if (out_ch.verdict !== want.verdict) begin
            $error("verdict: expected %0d, actual %0d", want.verdict, out_ch.verdict);
            fail_count++;
          end
          if (out_ch.count_after !== want.count_after) begin
            $error("count_after: expected %0d, actual %0d", want.count_after,
                   out_ch.count_after);
            fail_count++;
          end
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        if (in_ch.req_type) age_table();
        else verdicts_due.insert(verdicts_due.size(),
                                 judge_request(in_ch.request_key, in_ch.now_seconds));
      end
    end
    pending = verdicts_due.size();
  end

endmodule

FILE: tb/tb.sv
// Testbench top for the keyed request rate limiter: stimulus, register phases and the verdict.
module tb;
  import krl_pkg::*;

  // The watchdog limit leaves a wide margin over the slowest run.
  localparam int CYCLE_LIMIT   = 600000;
  // A tick walks the whole table without giving a verdict, so before touching
  // registers (and before the end) wait out at least one full walk.
  localparam int SETTLE_CYCLES = ENTRIES + 8;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int cycle_count = 0;
  // 0: sender idles 12%, receiver 83%; 1: the other way round; 2: no idling.
  int idle_mode = 0;

  logic [KEY_W-1:0]  key_pool[$];
  logic [TIME_W-1:0] wall_s;     // running request clock

  krl_in_if  req_ch ();
  krl_out_if verd_ch ();

  keyed_request_rate_limiter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (verd_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  krl_verdict_checker i_verdict_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (req_ch),
    .out_ch     (verd_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: ready is redrawn every cycle, so stalls land on any phase of a transfer.
  always @(negedge clk) begin
    case (idle_mode)
      0:       verd_ch.ready <= ($urandom_range(0, 99) >= 83);
      1:       verd_ch.ready <= ($urandom_range(0, 99) >= 12);
      default: verd_ch.ready <= 1'b1;
    endcase
  end

  function automatic logic sender_idles();
    case (idle_mode)
      0:       return ($urandom_range(0, 99) < 12);
      1:       return ($urandom_range(0, 99) < 83);
      default: return 1'b0;
    endcase
  endfunction

  // One item on the request channel. Valid is left high after the transfer; the next
  // call either drops it (idle) or replaces the payload at the following falling edge,
  // so valid never sees two updates in one step.
  task automatic send_item(input logic t, input logic [KEY_W-1:0] k,
                           input logic [TIME_W-1:0] s);
    @(negedge clk);
    while (sender_idles()) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= t;
    req_ch.request_key <= k;
    req_ch.now_seconds <= s;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  // Stop sending and wait until every verdict has come back, plus some cycles.
  task automatic drain(input int extra);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One register setting followed by random traffic over a pool of keys. Most requests
  // reuse pool keys so counts, gaps and aging really get exercised; a few are stray keys.
  task automatic run_phase(input int cnt_lim, input int gap, input int age_lim,
                           input int pool_n, input int tick_pct, input int n_items,
                           input int mode);
    logic [KEY_W-1:0] key;
    int               roll;
    drain(SETTLE_CYCLES);
    idle_mode = mode;
    write_reg(REG_COUNT_LIMIT, cnt_lim);
    write_reg(REG_MIN_GAP, gap);
    write_reg(REG_AGE_LIMIT, age_lim);
    key_pool.delete();
    repeat (pool_n) key_pool.insert(key_pool.size(), {$urandom(), $urandom()});
    repeat (n_items) begin
      // occasional full hold-off until the table has answered everything
      if ($urandom_range(0, 99) < 2) drain(0);
      if ($urandom_range(0, 99) < tick_pct) begin
        // key and time are don't-care on a tick; fill them with noise
        send_item(1'b1, {$urandom(), $urandom()}, $urandom());
      end else begin
        if ($urandom_range(0, 99) < 5) key = {$urandom(), $urandom()};
        else key = key_pool[$urandom_range(0, pool_n - 1)];
        roll = $urandom_range(0, 99);
        if (roll < 80) wall_s = wall_s + $urandom_range(0, 2 * gap + 2);
        else if (roll < 90) wall_s = wall_s - $urandom_range(0, gap + 1);   // clock went back
        else wall_s = $urandom();                                          // jump anywhere
        send_item(1'b0, key, wall_s);
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_wdata          = '0;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = 1'b0;
    req_ch.request_key = '0;
    req_ch.now_seconds = '0;
    wall_s             = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, reset register values (limit 10, gap 60, age 60).
    send_item(1'b0, '0, '0);                      // new key, all-zero key and time
    send_item(1'b0, '1, '1);                      // new key, all-ones key and time
    send_item(1'b0, '0, 32'd59);                  // too soon, one short of the gap
    send_item(1'b0, '0, 32'd60);                  // exactly the gap: accepted
    send_item(1'b0, '1, '0);                      // huge backward gap, no modular wrap
    send_item(1'b0, '0, '0);                      // backward by exactly the gap
    send_item(1'b0, '0, 32'd1);                   // too soon going forward
    send_item(1'b1, '1, '1);                      // tick
    send_item(1'b0, 64'h8000_0000_0000_0001, 32'h8000_0000);
    for (int i = 1; i <= 7; i++) send_item(1'b0, '0, TIME_W'(60 * i));  // count up to 10
    send_item(1'b0, '0, 32'd480);                 // limit used up, count still rises
    send_item(1'b0, '0, 32'd540);
    send_item(1'b1, '0, '0);

    // Random phases: limit, gap, age, pool size, tick %, items, idle mode.
    run_phase(3,   5,     4,   6,  12, 40,  0);   // busy keys, fast aging
    run_phase(255, 0,     255, 90, 1,  120, 0);   // many keys: table fills up
    run_phase(1,   65535, 255, 1,  0,  270, 1);   // one key hammered: count saturates
    run_phase(0,   65535, 0,   4,  20, 20,  1);   // zero limit, zero age
    run_phase(10,  60,    60,  12, 5,  20,  2);
    run_phase(200, 1,     1,   20, 25, 20,  2);

    drain(SETTLE_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
